[design/tccw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg: shared definitions for the text console cell writer
// Screen geometry, action and register codes, clear values, colour packing,
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tccw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 60;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);

    // Field widths
    localparam int COORD_W  = 8;
    localparam int LIM_W    = COORD_W + 1;
    localparam int CHAR_W   = 8;
    localparam int RGB_W    = 6;
    localparam int COLOUR_W = 12;
    localparam int PROD_W   = 17;

    // Action codes
    typedef enum logic [2:0] {
        ACT_PRINT      = 3'd0,
        ACT_SET_CURSOR = 3'd1,
        ACT_PUT_CHAR   = 3'd2,
        ACT_SET_COLOUR = 3'd3,
        ACT_CLEAR_RECT = 3'd4,
        ACT_READ       = 3'd5
    } t_action;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FORE_COLOUR = 2'd0,
        CFG_BACK_COLOUR = 2'd1,
        CFG_FIRST_LINE  = 2'd2,
        CFG_END_LINE    = 2'd3
    } t_cfg_index;

    // Reset values
    localparam logic [RGB_W-1:0]   FORE_COLOUR_RST = 6'd63;
    localparam logic [RGB_W-1:0]   BACK_COLOUR_RST = 6'd0;
    localparam logic [RGB_W-1:0]   FIRST_LINE_RST  = 6'd28;
    localparam logic [RGB_W-1:0]   END_LINE_RST    = 6'd58;
    localparam logic [COORD_W-1:0] CURSOR_COL_RST  = 8'd0;
    localparam logic [COORD_W-1:0] CURSOR_ROW_RST  = 8'd28;

    // Cleared cell: space, fg 63, bg 0
    localparam logic [CHAR_W-1:0]   CLEAR_CHAR   = 8'h20;
    localparam logic [COLOUR_W-1:0] CLEAR_COLOUR = 12'h333;

    // Interleave two RGB222 colours into three plane nibbles {bg pair, fg pair}
    function automatic logic [COLOUR_W-1:0] pack_colour(
        input logic [RGB_W-1:0] fg,
        input logic [RGB_W-1:0] bg
    );
        logic [COLOUR_W-1:0] word;
        word = '0;
        for (int p = 0; p < 3; p++) begin
            word[4*p +: 4] = {bg[2*p +: 2], fg[2*p +: 2]};
        end
        return word;
    endfunction

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // latch the accepted request
        logic wipe;        // zero one entry of the stores
        logic cell_setup;  // register the row base of the target cell
        logic wr_char;     // write the target cell's character
        logic wr_colour;   // write the target cell's colour word
        logic rd;          // issue a read of the target cell
        logic capture;     // take the read data
        logic cursor_set;  // move the cursor to the request's cell
        logic advance;     // step the cursor after a print
        logic rect_init;   // set up a rectangle walk
        logic rect_step;   // clear one cell of the rectangle
        logic out_load;    // load the result register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_action action;
        logic    print_wrap;
        logic    rect_empty;
        logic    rect_last;
        logic    wipe_last;
    } t_dp_stat;

endpackage

[design/tccw_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_ram: generic single-port RAM
// One write or read address per cycle, registered read data.
// ----------------------------------------------------------------------------
module tccw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/tccw_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_ctrl: sequencer of the text console cell writer
// Runs the clearing pass after reset, then steps each request through
// setup, execution or rectangle walk (a wrapping print has both) and result hand-off.
// ----------------------------------------------------------------------------
module tccw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tccw_pkg::t_dp_cmd  o_cmd,
    input  tccw_pkg::t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_SETUP,
        ST_EXEC,
        ST_READ_WAIT,
        ST_RECT_INIT,
        ST_RECT_RUN,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_accept;
    logic   out_free;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_accept   = i_in_valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        unique case (r_state)
            ST_WIPE: begin
                o_cmd.wipe = 1'b1;
                if (i_stat.wipe_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SETUP;
                end
            end
            ST_SETUP: begin
                o_cmd.cell_setup = 1'b1;
                if (i_stat.action == tccw_pkg::ACT_CLEAR_RECT) begin
                    n_state = ST_RECT_INIT;
                end else begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_DONE;
                unique case (i_stat.action)
                    tccw_pkg::ACT_PRINT: begin
                        o_cmd.wr_char   = 1'b1;
                        o_cmd.wr_colour = 1'b1;
                        o_cmd.advance   = 1'b1;
                        if (i_stat.print_wrap) begin
                            n_state = ST_RECT_INIT;
                        end
                    end
                    tccw_pkg::ACT_SET_CURSOR: o_cmd.cursor_set = 1'b1;
                    tccw_pkg::ACT_PUT_CHAR:   o_cmd.wr_char    = 1'b1;
                    tccw_pkg::ACT_SET_COLOUR: o_cmd.wr_colour  = 1'b1;
                    tccw_pkg::ACT_READ: begin
                        o_cmd.rd = 1'b1;
                        n_state  = ST_READ_WAIT;
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_READ_WAIT: begin
                o_cmd.capture = 1'b1;
                n_state       = ST_DONE;
            end
            ST_RECT_INIT: begin
                o_cmd.rect_init = 1'b1;
                n_state         = ST_RECT_RUN;
            end
            ST_RECT_RUN: begin
                if (i_stat.rect_empty) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.rect_step = 1'b1;
                    if (i_stat.rect_last) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_WIPE;
        endcase
    end

    // Hold state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WIPE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // A pending result is never overwritten
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("tccw_ctrl: result overwritten while stalled");

    // An accepted request makes the input side busy
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("tccw_ctrl: input not stalled after accept");

    // No result appears before the clearing pass ends
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WIPE) |-> !r_out_valid)
        else $error("tccw_ctrl: result during clearing pass");

endmodule

[design/tccw_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_dp: datapath of the text console cell writer
// Holds the configuration, cursor, request and result registers, the
// character and colour stores, the cell address unit and the rectangle walk.
// ----------------------------------------------------------------------------
module tccw_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tccw_pkg::t_dp_cmd             i_cmd,
    output tccw_pkg::t_dp_stat            o_stat,
    input  logic                          i_cfg_valid,
    input  logic [1:0]                    i_cfg_index,
    input  logic [tccw_pkg::RGB_W-1:0]    i_cfg_data,
    input  logic [2:0]                    i_action,
    input  logic [tccw_pkg::COORD_W-1:0]  i_col,
    input  logic [tccw_pkg::COORD_W-1:0]  i_row,
    input  logic [tccw_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tccw_pkg::RGB_W-1:0]    i_cell_fg,
    input  logic [tccw_pkg::RGB_W-1:0]    i_cell_bg,
    input  logic [tccw_pkg::COORD_W-1:0]  i_rect_width,
    input  logic [tccw_pkg::COORD_W-1:0]  i_rect_height,
    output logic [tccw_pkg::CHAR_W-1:0]   o_char_out,
    output logic [tccw_pkg::COLOUR_W-1:0] o_colour_out,
    output logic [tccw_pkg::COORD_W-1:0]  o_cursor_col_out,
    output logic [tccw_pkg::COORD_W-1:0]  o_cursor_row_out
);

    localparam int AW = tccw_pkg::ADDR_W;
    localparam int CW = tccw_pkg::COORD_W;
    localparam int LW = tccw_pkg::LIM_W;
    localparam int PW = tccw_pkg::PROD_W;
    localparam logic [LW-1:0] COLS_L = LW'(tccw_pkg::COLUMNS);
    localparam logic [LW-1:0] ROWS_L = LW'(tccw_pkg::ROWS);

    // Configuration and cursor
    logic [tccw_pkg::RGB_W-1:0] r_fore_colour;
    logic [tccw_pkg::RGB_W-1:0] r_back_colour;
    logic [tccw_pkg::RGB_W-1:0] r_first_line;
    logic [tccw_pkg::RGB_W-1:0] r_end_line;
    logic [CW-1:0]              r_cursor_col;
    logic [CW-1:0]              r_cursor_row;
    logic [CW-1:0]              n_cursor_col;
    logic [CW-1:0]              n_cursor_row;

    // Latched request
    logic [2:0]                    r_action;
    logic [CW-1:0]                 r_col;
    logic [CW-1:0]                 r_row;
    logic [tccw_pkg::CHAR_W-1:0]   r_char_code;
    logic [tccw_pkg::RGB_W-1:0]    r_cell_fg;
    logic [tccw_pkg::RGB_W-1:0]    r_cell_bg;
    logic [CW-1:0]                 r_rect_width;
    logic [CW-1:0]                 r_rect_height;

    // Read data and result
    logic [tccw_pkg::CHAR_W-1:0]   r_rd_char;
    logic [tccw_pkg::COLOUR_W-1:0] r_rd_colour;
    logic [tccw_pkg::CHAR_W-1:0]   r_char_out;
    logic [tccw_pkg::COLOUR_W-1:0] r_colour_out;
    logic [CW-1:0]                 r_cursor_col_out;
    logic [CW-1:0]                 r_cursor_row_out;

    // Address unit and rectangle walk
    logic [AW-1:0] r_wipe_addr;
    logic [AW-1:0] r_base;
    logic [CW-1:0] r_c0;
    logic [CW-1:0] r_wc;
    logic [CW-1:0] r_wr;
    logic [LW-1:0] r_col_lim;
    logic [LW-1:0] r_row_lim;
    logic          r_rect_empty;

    logic                          is_print;
    logic [CW-1:0]                 cell_col;
    logic [CW-1:0]                 cell_row;
    logic                          cell_on;
    logic [CW-1:0]                 mul_row;
    logic [PW-1:0]                 mul_prod;
    logic [PW-1:0]                 cell_sum;
    logic [PW-1:0]                 rect_sum;
    logic [AW-1:0]                 mem_addr;
    logic                          we_char;
    logic                          we_colour;
    logic [tccw_pkg::CHAR_W-1:0]   wdata_char;
    logic [tccw_pkg::COLOUR_W-1:0] wdata_colour;
    logic [tccw_pkg::CHAR_W-1:0]   q_char;
    logic [tccw_pkg::COLOUR_W-1:0] q_colour;
    logic [LW-1:0]                 col_next;
    logic [LW-1:0]                 row_next;
    logic                          print_wrap;
    logic [CW-1:0]                 rc0;
    logic [CW-1:0]                 rr0;
    logic [LW-1:0]                 rw;
    logic [LW-1:0]                 rh;
    logic [LW-1:0]                 col_sum;
    logic [LW-1:0]                 row_sum;
    logic [LW-1:0]                 col_lim;
    logic [LW-1:0]                 row_lim;
    logic                          wc_end;
    logic                          wr_end;

    // Target cell: the cursor for print, the request's cell otherwise
    assign is_print = (r_action == tccw_pkg::ACT_PRINT);
    assign cell_col = is_print ? r_cursor_col : r_col;
    assign cell_row = is_print ? r_cursor_row : r_row;
    assign cell_on  = ({1'b0, cell_col} < COLS_L) && ({1'b0, cell_row} < ROWS_L);

    // Row base multiply, shared by cell setup and rectangle setup
    assign mul_row  = i_cmd.rect_init ? rr0 : cell_row;
    assign mul_prod = PW'(mul_row) * PW'(tccw_pkg::COLUMNS);
    assign cell_sum = PW'(r_base) + PW'(cell_col);
    assign rect_sum = PW'(r_base) + PW'(r_wc);

    // Cursor step for print
    always_comb begin
        col_next     = {1'b0, r_cursor_col} + LW'(1);
        row_next     = {1'b0, r_cursor_row};
        n_cursor_col = col_next[CW-1:0];
        if (col_next >= COLS_L) begin
            n_cursor_col = '0;
            row_next     = {1'b0, r_cursor_row} + LW'(1);
        end
        print_wrap   = (row_next >= LW'(r_end_line));
        n_cursor_row = print_wrap ? CW'(r_first_line) : row_next[CW-1:0];
    end

    // Rectangle bounds: print clears the window over the full width
    always_comb begin
        rc0 = is_print ? '0 : r_col;
        rr0 = is_print ? CW'(r_first_line) : r_row;
        rw  = is_print ? COLS_L : {1'b0, r_rect_width};
        if (is_print) begin
            rh = (r_end_line > r_first_line) ? LW'(r_end_line - r_first_line) : ROWS_L;
        end else begin
            rh = {1'b0, r_rect_height};
        end
        col_sum = {1'b0, rc0} + rw;
        row_sum = {1'b0, rr0} + rh;
        col_lim = (col_sum < COLS_L) ? col_sum : COLS_L;
        row_lim = (row_sum < ROWS_L) ? row_sum : ROWS_L;
    end

    assign wc_end = ({1'b0, r_wc} + LW'(1)) == r_col_lim;
    assign wr_end = ({1'b0, r_wr} + LW'(1)) == r_row_lim;

    // Store port: clearing pass, rectangle walk or single cell
    always_comb begin
        if (i_cmd.wipe) begin
            mem_addr     = r_wipe_addr;
            wdata_char   = '0;
            wdata_colour = '0;
            we_char      = 1'b1;
            we_colour    = 1'b1;
        end else if (i_cmd.rect_step) begin
            mem_addr     = rect_sum[AW-1:0];
            wdata_char   = tccw_pkg::CLEAR_CHAR;
            wdata_colour = tccw_pkg::CLEAR_COLOUR;
            we_char      = 1'b1;
            we_colour    = 1'b1;
        end else begin
            mem_addr     = cell_sum[AW-1:0];
            wdata_char   = r_char_code;
            wdata_colour = is_print ? tccw_pkg::pack_colour(r_fore_colour, r_back_colour)
                                    : tccw_pkg::pack_colour(r_cell_fg, r_cell_bg);
            we_char      = i_cmd.wr_char && cell_on;
            we_colour    = i_cmd.wr_colour && cell_on;
        end
    end

    tccw_ram #(
        .WIDTH (tccw_pkg::CHAR_W),
        .DEPTH (tccw_pkg::CELLS)
    ) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (we_char),
        .i_addr  (mem_addr),
        .i_wdata (wdata_char),
        .o_rdata (q_char)
    );

    tccw_ram #(
        .WIDTH (tccw_pkg::COLOUR_W),
        .DEPTH (tccw_pkg::CELLS)
    ) u_colour_ram (
        .i_clk   (i_clk),
        .i_we    (we_colour),
        .i_addr  (mem_addr),
        .i_wdata (wdata_colour),
        .o_rdata (q_colour)
    );

    // Configuration, cursor and clearing counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fore_colour <= tccw_pkg::FORE_COLOUR_RST;
            r_back_colour <= tccw_pkg::BACK_COLOUR_RST;
            r_first_line  <= tccw_pkg::FIRST_LINE_RST;
            r_end_line    <= tccw_pkg::END_LINE_RST;
            r_cursor_col  <= tccw_pkg::CURSOR_COL_RST;
            r_cursor_row  <= tccw_pkg::CURSOR_ROW_RST;
            r_wipe_addr   <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (tccw_pkg::t_cfg_index'(i_cfg_index))
                    tccw_pkg::CFG_FORE_COLOUR: r_fore_colour <= i_cfg_data;
                    tccw_pkg::CFG_BACK_COLOUR: r_back_colour <= i_cfg_data;
                    tccw_pkg::CFG_FIRST_LINE:  r_first_line  <= i_cfg_data;
                    tccw_pkg::CFG_END_LINE:    r_end_line    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.advance) begin
                r_cursor_col <= n_cursor_col;
                r_cursor_row <= n_cursor_row;
            end else if (i_cmd.cursor_set && cell_on) begin
                r_cursor_col <= r_col;
                r_cursor_row <= r_row;
            end
            if (i_cmd.wipe) begin
                r_wipe_addr <= r_wipe_addr + AW'(1);
            end
        end
    end

    // Request, walk and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action      <= i_action;
            r_col         <= i_col;
            r_row         <= i_row;
            r_char_code   <= i_char_code;
            r_cell_fg     <= i_cell_fg;
            r_cell_bg     <= i_cell_bg;
            r_rect_width  <= i_rect_width;
            r_rect_height <= i_rect_height;
            r_rd_char     <= '0;
            r_rd_colour   <= '0;
        end
        if (i_cmd.capture) begin
            r_rd_char   <= cell_on ? q_char : '0;
            r_rd_colour <= cell_on ? q_colour : '0;
        end
        if (i_cmd.cell_setup || i_cmd.rect_init) begin
            r_base <= mul_prod[AW-1:0];
        end
        if (i_cmd.rect_init) begin
            r_c0         <= rc0;
            r_wc         <= rc0;
            r_wr         <= rr0;
            r_col_lim    <= col_lim;
            r_row_lim    <= row_lim;
            r_rect_empty <= ({1'b0, rc0} >= col_lim) || ({1'b0, rr0} >= row_lim);
        end
        if (i_cmd.rect_step) begin
            if (wc_end) begin
                r_wc   <= r_c0;
                r_wr   <= r_wr + CW'(1);
                r_base <= r_base + AW'(tccw_pkg::COLUMNS);
            end else begin
                r_wc <= r_wc + CW'(1);
            end
        end
        if (i_cmd.out_load) begin
            r_char_out       <= r_rd_char;
            r_colour_out     <= r_rd_colour;
            r_cursor_col_out <= r_cursor_col;
            r_cursor_row_out <= r_cursor_row;
        end
    end

    assign o_stat.action     = tccw_pkg::t_action'(r_action);
    assign o_stat.print_wrap = print_wrap;
    assign o_stat.rect_empty = r_rect_empty;
    assign o_stat.rect_last  = wc_end && wr_end;
    assign o_stat.wipe_last  = (r_wipe_addr == AW'(tccw_pkg::CELLS - 1));

    assign o_char_out       = r_char_out;
    assign o_colour_out     = r_colour_out;
    assign o_cursor_col_out = r_cursor_col_out;
    assign o_cursor_row_out = r_cursor_row_out;

    // The rectangle walk stays on the screen
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rect_step |-> (({1'b0, r_wc} < COLS_L) && ({1'b0, r_wr} < ROWS_L)))
        else $error("tccw_dp: rectangle walk left the screen");

    // The clearing counter never passes the last entry
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wipe |-> (PW'(r_wipe_addr) < PW'(tccw_pkg::CELLS)))
        else $error("tccw_dp: clearing pass out of range");

    // Store writes stay inside the stores
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we_char || we_colour) |-> (PW'(mem_addr) < PW'(tccw_pkg::CELLS)))
        else $error("tccw_dp: store write out of range");

endmodule

[design/text_console_cell_writer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_writer: text-mode character and colour store with cursor
// Top level: request and result channels, configuration port, controller
// and datapath.
// ----------------------------------------------------------------------------
// After reset the block zeroes both stores, one cell per cycle, across all
// 4800 cells (COLUMNS x ROWS); input stays stalled during that pass while
// configuration writes are taken. It then works on one request at a time,
// stepped by the controller through the single-port cell stores: each request
// is latched, set up, executed and handed off as a result; read adds a wait
// for the registered store read; print, when the cursor reaches the end line,
// then clears the window (COLUMNS x on-screen window rows), one cell per cycle;
// clear rect skips execution and clears the on-screen cells of the rectangle,
// one cell per cycle. A finished result waits in the output register while the
// next request is accepted; a request that finishes while the previous result
// is still stalled holds in its last step until that result is taken.
// Configuration is always ready and should only be written while the block
// is idle.
module text_console_cell_writer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [2:0]                    i_action,
    input  logic [tccw_pkg::COORD_W-1:0]  i_col,
    input  logic [tccw_pkg::COORD_W-1:0]  i_row,
    input  logic [tccw_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tccw_pkg::RGB_W-1:0]    i_cell_fg,
    input  logic [tccw_pkg::RGB_W-1:0]    i_cell_bg,
    input  logic [tccw_pkg::COORD_W-1:0]  i_rect_width,
    input  logic [tccw_pkg::COORD_W-1:0]  i_rect_height,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tccw_pkg::CHAR_W-1:0]   o_char_out,
    output logic [tccw_pkg::COLOUR_W-1:0] o_colour_out,
    output logic [tccw_pkg::COORD_W-1:0]  o_cursor_col_out,
    output logic [tccw_pkg::COORD_W-1:0]  o_cursor_row_out,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [tccw_pkg::RGB_W-1:0]    i_cfg_data
);

    tccw_pkg::t_dp_cmd  cmd;
    tccw_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    // Sequencer
    tccw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // Stores, cursor and configuration
    tccw_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_action         (i_action),
        .i_col            (i_col),
        .i_row            (i_row),
        .i_char_code      (i_char_code),
        .i_cell_fg        (i_cell_fg),
        .i_cell_bg        (i_cell_bg),
        .i_rect_width     (i_rect_width),
        .i_rect_height    (i_rect_height),
        .o_char_out       (o_char_out),
        .o_colour_out     (o_colour_out),
        .o_cursor_col_out (o_cursor_col_out),
        .o_cursor_row_out (o_cursor_row_out)
    );

endmodule

[tb/sv/tccw_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_checker: result predictor and scoreboard for the text console writer
// Watches the request, result and configuration channels. Keeps a shadow
// copy of the screen stores, cursor and print settings, works out the
// result of every accepted request and compares each delivered result with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tccw_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_col,
    input  logic [7:0]  i_row,
    input  logic [7:0]  i_char_code,
    input  logic [5:0]  i_cell_fg,
    input  logic [5:0]  i_cell_bg,
    input  logic [7:0]  i_rect_width,
    input  logic [7:0]  i_rect_height,
    // result channel
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_char_out,
    input  logic [11:0] i_colour_out,
    input  logic [7:0]  i_cursor_col_out,
    input  logic [7:0]  i_cursor_row_out,
    // configuration write channel
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_data,
    // status to the testbench top
    output int          o_fail_count,
    output int          o_pending
);

    localparam int unsigned SCREEN_COLS  = 80;
    localparam int unsigned SCREEN_ROWS  = 60;
    localparam int unsigned SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
    localparam logic [7:0]  BLANK_CHAR   = 8'h20;
    localparam logic [11:0] BLANK_COLOUR = 12'h333;

    typedef struct packed {
        logic [7:0]  chr;
        logic [11:0] colour;
        logic [7:0]  cur_col;
        logic [7:0]  cur_row;
    } t_cell_result;

    // Shadow screen, cursor and print settings
    logic [7:0]   shadow_char   [SCREEN_CELLS];
    logic [11:0]  shadow_colour [SCREEN_CELLS];
    int unsigned  cur_col;
    int unsigned  cur_row;
    logic [5:0]   pen_fore;
    logic [5:0]   pen_back;
    logic [5:0]   win_first;
    logic [5:0]   win_end;

    t_cell_result expected_results [$];
    int           fail_total = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic bit visible(int unsigned c, int unsigned r);
        return c < SCREEN_COLS && r < SCREEN_ROWS;
    endfunction

    // Interleave fg and bg two bits at a time: {bg pair, fg pair} per plane
    function automatic logic [11:0] colour_word(logic [5:0] fg, logic [5:0] bg);
        return {bg[5:4], fg[5:4], bg[3:2], fg[3:2], bg[1:0], fg[1:0]};
    endfunction

    function automatic void blank_rect(int unsigned c0, int unsigned r0,
                                       int unsigned w, int unsigned h);
        for (int unsigned rr = r0; rr < r0 + h && rr < SCREEN_ROWS; rr++) begin
            for (int unsigned cc = c0; cc < c0 + w && cc < SCREEN_COLS; cc++) begin
                shadow_char[cc + rr * SCREEN_COLS]   = BLANK_CHAR;
                shadow_colour[cc + rr * SCREEN_COLS] = BLANK_COLOUR;
            end
        end
    endfunction

    // Write at the cursor, advance it and wrap the print window
    function automatic void print_at_cursor(logic [7:0] ch);
        int unsigned span;
        if (visible(cur_col, cur_row)) begin
            shadow_colour[cur_col + cur_row * SCREEN_COLS] = colour_word(pen_fore, pen_back);
            shadow_char[cur_col + cur_row * SCREEN_COLS]   = ch;
        end
        cur_col++;
        if (cur_col >= SCREEN_COLS) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= win_end) begin
            cur_row = win_first;
            // an inverted window clears down to the bottom of the screen
            span = (win_end > win_first) ? win_end - win_first : SCREEN_ROWS;
            blank_rect(0, win_first, SCREEN_COLS, span);
        end
    endfunction

    function automatic t_cell_result screen_step(
        logic [2:0] act, logic [7:0] c, logic [7:0] r, logic [7:0] ch,
        logic [5:0] fg, logic [5:0] bg, logic [7:0] w, logic [7:0] h
    );
        t_cell_result res;
        res = '0;
        case (act)
            tccw_pkg::ACT_PRINT:      print_at_cursor(ch);
            tccw_pkg::ACT_SET_CURSOR: begin
                if (visible(c, r)) begin
                    cur_col = c;
                    cur_row = r;
                end
            end
            tccw_pkg::ACT_PUT_CHAR: begin
                if (visible(c, r)) shadow_char[c + r * SCREEN_COLS] = ch;
            end
            tccw_pkg::ACT_SET_COLOUR: begin
                if (visible(c, r)) shadow_colour[c + r * SCREEN_COLS] = colour_word(fg, bg);
            end
            tccw_pkg::ACT_CLEAR_RECT: blank_rect(c, r, w, h);
            tccw_pkg::ACT_READ: begin
                if (visible(c, r)) begin
                    res.chr    = shadow_char[c + r * SCREEN_COLS];
                    res.colour = shadow_colour[c + r * SCREEN_COLS];
                end
            end
            default: ;
        endcase
        res.cur_col = cur_col[7:0];
        res.cur_row = cur_row[7:0];
        return res;
    endfunction

    function automatic void reset_screen();
        for (int i = 0; i < SCREEN_CELLS; i++) begin
            shadow_char[i]   = '0;
            shadow_colour[i] = '0;
        end
        cur_col   = 0;
        cur_row   = 28;
        pen_fore  = 6'd63;
        pen_back  = 6'd0;
        win_first = 6'd28;
        win_end   = 6'd58;
    endfunction

    function automatic void compare_field(string name, logic [11:0] want, logic [11:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_total++;
        end
    endfunction

    // Track settings, retire results, then queue the new request's result
    always @(posedge i_clk) begin
        t_cell_result want;
        if (!i_rst_n) begin
            reset_screen();
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (tccw_pkg::t_cfg_index'(i_cfg_index))
                    tccw_pkg::CFG_FORE_COLOUR: pen_fore  = i_cfg_data;
                    tccw_pkg::CFG_BACK_COLOUR: pen_back  = i_cfg_data;
                    tccw_pkg::CFG_FIRST_LINE:  win_first = i_cfg_data;
                    tccw_pkg::CFG_END_LINE:    win_end   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %0h/%0h/%0h/%0h",
                             $time, i_char_out, i_colour_out, i_cursor_col_out,
                             i_cursor_row_out);
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("char_out", 12'(want.chr), 12'(i_char_out));
                    compare_field("colour_out", want.colour, i_colour_out);
                    compare_field("cursor_col_out", 12'(want.cur_col),
                                  12'(i_cursor_col_out));
                    compare_field("cursor_row_out", 12'(want.cur_row),
                                  12'(i_cursor_row_out));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(screen_step(i_action, i_col, i_row, i_char_code,
                                                       i_cell_fg, i_cell_bg, i_rect_width,
                                                       i_rect_height));
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_total;
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the text console cell writer
// Drives a directed set of requests covering screen edges, off-screen cells,
// window wraps and every action, then random phases under several print
// settings with random gaps and output stalls. The checker predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int         WATCHDOG_LIMIT = 30000;
    localparam int         PHASES         = 8;
    localparam int         PHASE_ITEMS    = 180;
    localparam logic [2:0] ACT_SPARE_A    = 3'd6;
    localparam logic [2:0] ACT_SPARE_B    = 3'd7;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_action      = '0;
    logic [7:0]  i_col         = '0;
    logic [7:0]  i_row         = '0;
    logic [7:0]  i_char_code   = '0;
    logic [5:0]  i_cell_fg     = '0;
    logic [5:0]  i_cell_bg     = '0;
    logic [7:0]  i_rect_width  = '0;
    logic [7:0]  i_rect_height = '0;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    logic [7:0]  o_char_out;
    logic [11:0] o_colour_out;
    logic [7:0]  o_cursor_col_out;
    logic [7:0]  o_cursor_row_out;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = '0;
    logic [5:0]  i_cfg_data    = '0;

    int          fail_count;
    int          pending;
    int          idle_cycles   = 0;
    int          stall_hold    = 0;
    int          burst_left    = 0;
    logic [7:0]  last_col      = '0;
    logic [7:0]  last_row      = '0;
    logic [5:0]  win_first_now = 6'd28;
    logic [5:0]  win_end_now   = 6'd58;

    // Print settings per phase: tiny, bottom-row, off-screen, inverted and full windows
    logic [5:0] phase_fore  [PHASES] = '{6'd0, 6'd63, 6'd42, 6'd21, 6'd0, 6'd63, 6'd12, 6'd63};
    logic [5:0] phase_back  [PHASES] = '{6'd63, 6'd0, 6'd21, 6'd42, 6'd0, 6'd63, 6'd51, 6'd0};
    logic [5:0] phase_first [PHASES] = '{6'd0, 6'd59, 6'd60, 6'd58, 6'd0, 6'd57, 6'd20, 6'd28};
    logic [5:0] phase_end   [PHASES] = '{6'd1, 6'd60, 6'd60, 6'd0, 6'd60, 6'd40, 6'd22, 6'd58};

    text_console_cell_writer DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_col            (i_col),
        .i_row            (i_row),
        .i_char_code      (i_char_code),
        .i_cell_fg        (i_cell_fg),
        .i_cell_bg        (i_cell_bg),
        .i_rect_width     (i_rect_width),
        .i_rect_height    (i_rect_height),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_char_out       (o_char_out),
        .o_colour_out     (o_colour_out),
        .o_cursor_col_out (o_cursor_col_out),
        .o_cursor_row_out (o_cursor_row_out),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    tccw_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_col            (i_col),
        .i_row            (i_row),
        .i_char_code      (i_char_code),
        .i_cell_fg        (i_cell_fg),
        .i_cell_bg        (i_cell_bg),
        .i_rect_width     (i_rect_width),
        .i_rect_height    (i_rect_height),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_char_out       (o_char_out),
        .i_colour_out     (o_colour_out),
        .i_cursor_col_out (o_cursor_col_out),
        .i_cursor_row_out (o_cursor_row_out),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always #5 i_clk = ~i_clk;

    // Output stall: short bursts mostly, some long holds, some long open stretches
    always @(posedge i_clk) begin
        int roll;
        if (stall_hold == 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                i_out_stall <= 1'b0;
                stall_hold  <= $urandom_range(1, 6);
            end else if (roll < 85) begin
                i_out_stall <= 1'b1;
                stall_hold  <= $urandom_range(1, 3);
            end else if (roll < 95) begin
                i_out_stall <= 1'b0;
                stall_hold  <= $urandom_range(40, 200);
            end else begin
                i_out_stall <= 1'b1;
                stall_hold  <= $urandom_range(10, 60);
            end
        end else begin
            stall_hold <= stall_hold - 1;
        end
    end

    // Watchdog: end the run when nothing moves on any channel for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding", $time, pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Gap before a request: mostly none or short, a few long, some bursts with none
    function automatic int pick_gap();
        int roll;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 60) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // Present one request and hold it until accepted
    task automatic issue_request(
        input logic [2:0] act, input logic [7:0] c, input logic [7:0] r,
        input logic [7:0] ch, input logic [5:0] fg, input logic [5:0] bg,
        input logic [7:0] w, input logic [7:0] h
    );
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_col         <= c;
        i_row         <= r;
        i_char_code   <= ch;
        i_cell_fg     <= fg;
        i_cell_bg     <= bg;
        i_rect_width  <= w;
        i_rect_height <= h;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic write_register(input tccw_pkg::t_cfg_index idx, input logic [5:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic write_settings(input logic [5:0] fore, input logic [5:0] back,
                                  input logic [5:0] first, input logic [5:0] last);
        write_register(tccw_pkg::CFG_FORE_COLOUR, fore);
        write_register(tccw_pkg::CFG_BACK_COLOUR, back);
        write_register(tccw_pkg::CFG_FIRST_LINE, first);
        write_register(tccw_pkg::CFG_END_LINE, last);
        i_cfg_valid   <= 1'b0;
        win_first_now  = first;
        win_end_now    = last;
    endtask

    // Drain all results and let the block go idle
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || o_in_stall);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_request();
        logic [2:0] act;
        logic [7:0] c, r, ch, w, h;
        logic [5:0] fg, bg;
        int         roll;
        roll = $urandom_range(0, 99);
        c    = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 79)) : 8'($urandom);
        r    = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 59)) : 8'($urandom);
        ch   = 8'($urandom);
        fg   = 6'($urandom);
        bg   = 6'($urandom);
        // keep most rectangles small; a few may cover the whole screen
        if ($urandom_range(0, 99) < 95) begin
            w = 8'($urandom_range(0, 10));
            h = 8'($urandom_range(0, 6));
        end else begin
            w = 8'($urandom);
            h = 8'($urandom);
        end
        if (roll < 40)      act = tccw_pkg::ACT_PRINT;
        else if (roll < 50) act = tccw_pkg::ACT_SET_CURSOR;
        else if (roll < 60) act = tccw_pkg::ACT_PUT_CHAR;
        else if (roll < 70) act = tccw_pkg::ACT_SET_COLOUR;
        else if (roll < 78) act = tccw_pkg::ACT_CLEAR_RECT;
        else if (roll < 98) act = tccw_pkg::ACT_READ;
        else                act = roll[0] ? ACT_SPARE_A : ACT_SPARE_B;
        // read back the last written cell half of the time
        if (act == tccw_pkg::ACT_READ && $urandom_range(0, 1) == 1) begin
            c = last_col;
            r = last_row;
        end
        if (act == tccw_pkg::ACT_PUT_CHAR || act == tccw_pkg::ACT_SET_COLOUR) begin
            last_col = c;
            last_row = r;
        end
        issue_request(act, c, r, ch, fg, bg, w, h);
    endtask

    // Place the cursor inside the print window, when it has rows on screen, and print a run
    task automatic print_run(output int sent);
        int         count;
        logic [7:0] r;
        count = $urandom_range(10, 50);
        if (win_end_now > win_first_now && win_first_now < 60)
            r = 8'($urandom_range(win_first_now, win_end_now - 1));
        else
            r = 8'($urandom_range(0, 59));
        issue_request(tccw_pkg::ACT_SET_CURSOR, 8'($urandom_range(0, 79)), r, 8'($urandom),
                      6'($urandom), 6'($urandom), 8'($urandom), 8'($urandom));
        repeat (count) begin
            issue_request(tccw_pkg::ACT_PRINT, 8'($urandom), 8'($urandom), 8'($urandom),
                          6'($urandom), 6'($urandom), 8'($urandom), 8'($urandom));
        end
        sent = count + 1;
    endtask

    initial begin
        int sent;
        int run_len;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: screen corners, off-screen cells, window wraps, all actions
        issue_request(tccw_pkg::ACT_READ, 8'd0, 8'd0, 8'd0, 6'd0, 6'd0, 8'd0, 8'd0);
        issue_request(tccw_pkg::ACT_PRINT, 8'd0, 8'd0, 8'h41, 6'd0, 6'd0, 8'd0, 8'd0);
        issue_request(tccw_pkg::ACT_READ, 8'd0, 8'd28, 8'd0, 6'd0, 6'd0, 8'd0, 8'd0);
        issue_request(tccw_pkg::ACT_SET_CURSOR, 8'd79, 8'd57, 8'd0, 6'd0, 6'd0, 8'd0, 8'd0);
        issue_request(tccw_pkg::ACT_PRINT, 8'd0, 8'd0, 8'hff, 6'd0, 6'd0, 8'd0, 8'd0);
        issue_request(tccw_pkg::ACT_READ, 8'd79, 8'd57, 8'd0, 6'd0, 6'd0, 8'd0, 8'd0);
        issue_request(tccw_pkg::ACT_SET_CURSOR, 8'd80, 8'd0, 8'd0, 6'd0, 6'd0, 8'd0, 8'd0);
        issue_request(tccw_pkg::ACT_SET_CURSOR, 8'd0, 8'd60, 8'd0, 6'd0, 6'd0, 8'd0, 8'd0);
        issue_request(tccw_pkg::ACT_SET_CURSOR, 8'hff, 8'hff, 8'd0, 6'd0, 6'd0, 8'd0, 8'd0);
        issue_request(tccw_pkg::ACT_SET_CURSOR, 8'd79, 8'd59, 8'd0, 6'd0, 6'd0, 8'd0, 8'd0);
        issue_request(tccw_pkg::ACT_PRINT, 8'd0, 8'd0, 8'h00, 6'd0, 6'd0, 8'd0, 8'd0);
        issue_request(tccw_pkg::ACT_PUT_CHAR, 8'd79, 8'd59, 8'hff, 6'd0, 6'd0, 8'd0, 8'd0);
        issue_request(tccw_pkg::ACT_PUT_CHAR, 8'd80, 8'd59, 8'h55, 6'd0, 6'd0, 8'd0, 8'd0);
        issue_request(tccw_pkg::ACT_SET_COLOUR, 8'd79, 8'd59, 8'd0, 6'd63, 6'd0, 8'd0, 8'd0);
        issue_request(tccw_pkg::ACT_SET_COLOUR, 8'd0, 8'd0, 8'd0, 6'd0, 6'd63, 8'd0, 8'd0);
        issue_request(tccw_pkg::ACT_SET_COLOUR, 8'd1, 8'd0, 8'd0, 6'h2a, 6'h15, 8'd0, 8'd0);
        issue_request(tccw_pkg::ACT_SET_COLOUR, 8'd0, 8'hff, 8'd0, 6'd63, 6'd63, 8'd0, 8'd0);
        issue_request(tccw_pkg::ACT_READ, 8'd79, 8'd59, 8'd0, 6'd0, 6'd0, 8'd0, 8'd0);
        issue_request(tccw_pkg::ACT_READ, 8'd1, 8'd0, 8'd0, 6'd0, 6'd0, 8'd0, 8'd0);
        // rectangle hanging off the bottom right corner, then an empty one
        issue_request(tccw_pkg::ACT_CLEAR_RECT, 8'd78, 8'd58, 8'd0, 6'd0, 6'd0, 8'hff, 8'hff);
        issue_request(tccw_pkg::ACT_CLEAR_RECT, 8'd0, 8'd0, 8'd0, 6'd0, 6'd0, 8'd0, 8'd5);
        issue_request(tccw_pkg::ACT_READ, 8'd79, 8'd59, 8'd0, 6'd0, 6'd0, 8'd0, 8'd0);
        issue_request(tccw_pkg::ACT_READ, 8'hff, 8'hff, 8'd0, 6'd0, 6'd0, 8'd0, 8'd0);
        issue_request(ACT_SPARE_A, 8'hff, 8'hff, 8'hff, 6'd63, 6'd63, 8'hff, 8'hff);
        issue_request(ACT_SPARE_B, 8'hff, 8'hff, 8'hff, 6'd63, 6'd63, 8'hff, 8'hff);

        // Random phases, one print setting each
        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_settings(phase_fore[p], phase_back[p], phase_first[p], phase_end[p]);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 4) begin
                    print_run(run_len);
                    sent += run_len;
                end else begin
                    random_request();
                    sent++;
                end
            end
        end

        // Drain and give the verdict
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
